// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ----- hw/rtl/brm_pkg.sv -----
package brm_pkg;

  localparam int THR_BITS   = 12;
  localparam int WIN_BITS   = 10;
  localparam int SCALE_BITS = 6;
  localparam int BEAT_BITS  = 10;
  localparam int RATE_BITS  = 15;
  localparam int PROD_BITS  = BEAT_BITS + SCALE_BITS;
  localparam int CFG_BITS   = 12;
  localparam int IDX_BITS   = 2;
  localparam int QUO_BITS   = 9;
  localparam int REM_BITS   = 7;

  localparam logic [THR_BITS-1:0]   RESET_THRESHOLD = 12'd100;
  localparam logic [WIN_BITS-1:0]   RESET_WINDOW    = 10'd500;
  localparam logic [SCALE_BITS-1:0] RESET_SCALE     = 6'd12;

  localparam logic OP_BUTTON = 1'b1;

  localparam logic [IDX_BITS-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_WINDOW    = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_SCALE     = 2'd2;

  localparam logic [BEAT_BITS-1:0] BEAT_MAX = 10'd1023;
  localparam logic [RATE_BITS-1:0] RATE_MAX = 15'd32767;

  // n / 100 == (n * 5243) >> 19 for every 15-bit n
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic [THR_BITS-1:0]   threshold;
    logic [WIN_BITS-1:0]   window_length;
    logic [SCALE_BITS-1:0] rate_scale;
  } cfg_t;

  typedef struct packed {
    logic [BEAT_BITS-1:0]  beats;
    logic [SCALE_BITS-1:0] scale;
    logic                  cleared;
  } beat_word_t;

  typedef struct packed {
    logic [RATE_BITS-1:0] rate;
    logic                 cleared;
  } rate_word_t;

  typedef struct packed {
    logic [RATE_BITS-1:0] rate;
    logic [QUO_BITS-1:0]  quot;
    logic                 cleared;
  } quot_word_t;

  function automatic logic [3:0] tens_of(input logic [REM_BITS-1:0] r);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (r >= REM_BITS'(k * 10)) t = 4'(k);
    end
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [REM_BITS-1:0] r,
                                         input logic [3:0] t);
    logic [REM_BITS-1:0] tx10;
    tx10 = REM_BITS'({t, 3'b000}) + REM_BITS'({t, 1'b0});
    return 4'(r - tx10);
  endfunction

endpackage

// ----- hw/rtl/brm_cfg.sv -----
module brm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [brm_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [brm_pkg::CFG_BITS-1:0]   cfg_data,
  output brm_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold     <= brm_pkg::RESET_THRESHOLD;
      cfg.window_length <= brm_pkg::RESET_WINDOW;
      cfg.rate_scale    <= brm_pkg::RESET_SCALE;
    end else if (cfg_valid) begin
      case (cfg_index)
        brm_pkg::REG_THRESHOLD: begin
          cfg.threshold <= cfg_data[brm_pkg::THR_BITS-1:0];
        end
        brm_pkg::REG_WINDOW: begin
          cfg.window_length <= cfg_data[brm_pkg::WIN_BITS-1:0];
        end
        brm_pkg::REG_SCALE: begin
          cfg.rate_scale <= cfg_data[brm_pkg::SCALE_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/brm_step.sv -----
`include "assert_macros.svh"

module brm_step #(
  parameter int SAMPLE_BITS = 12,
  parameter int MAX_WINDOW  = 1023
) (
  input  logic                 clk,
  input  logic                 rst,
  input  brm_pkg::cfg_t        cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 operation,
  input  logic [11:0]          sample,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output brm_pkg::beat_word_t  dn_word
);

  localparam int CMP_BITS = (SAMPLE_BITS < 12) ? SAMPLE_BITS : 12;
  localparam int WIN_MAX  = (1 << brm_pkg::WIN_BITS) - 1;
  localparam int LEN_MAX  = (MAX_WINDOW < WIN_MAX) ? MAX_WINDOW : WIN_MAX;
  localparam int CNT_BITS = $clog2(LEN_MAX + 1);

  logic                 s1_valid;
  logic                 s1_op;
  logic [11:0]          s1_sample;
  logic                 s1_adv;
  logic                 dn_room;

  logic                 active, active_next;
  logic                 running, running_next;
  logic                 level_high, level_next;
  logic [CNT_BITS-1:0]  sample_count, count_next, count_inc;
  logic [brm_pkg::BEAT_BITS-1:0] beat_count, beats_next, beats_inc;
  logic                 emit;
  brm_pkg::beat_word_t  word_next;

  logic                 low;
  logic [brm_pkg::WIN_BITS-1:0] len_clip;
  logic [CNT_BITS-1:0]  len;

  assign low = s1_sample[CMP_BITS-1:0] < cfg.threshold[CMP_BITS-1:0];

  always_comb begin
    len_clip = (cfg.window_length > brm_pkg::WIN_BITS'(LEN_MAX)) ?
               brm_pkg::WIN_BITS'(LEN_MAX) : cfg.window_length;
    len = (len_clip == '0) ? CNT_BITS'(1) : len_clip[CNT_BITS-1:0];
  end

  assign count_inc = sample_count + CNT_BITS'(1);
  assign beats_inc = (low && level_high && beat_count != brm_pkg::BEAT_MAX) ?
                     beat_count + brm_pkg::BEAT_BITS'(1) : beat_count;

  always_comb begin
    active_next  = active;
    running_next = running;
    level_next   = level_high;
    count_next   = sample_count;
    beats_next   = beat_count;
    emit         = 1'b0;
    word_next    = '0;
    if (s1_valid) begin
      if (s1_op == brm_pkg::OP_BUTTON) begin
        active_next  = !active;
        running_next = 1'b0;
        level_next   = 1'b0;
        count_next   = '0;
        beats_next   = '0;
        if (active) begin
          emit              = 1'b1;
          word_next.cleared = 1'b1;
        end
      end else if (active) begin
        if (!running) begin
          if (low) begin
            running_next = 1'b1;
            level_next   = 1'b0;
            count_next   = '0;
            beats_next   = '0;
          end
        end else begin
          level_next = !low;
          beats_next = beats_inc;
          count_next = count_inc;
          if (count_inc >= len) begin
            emit            = 1'b1;
            word_next.beats = beats_inc;
            word_next.scale = cfg.rate_scale;
            running_next    = 1'b0;
            level_next      = 1'b0;
            count_next      = '0;
            beats_next      = '0;
          end
        end
      end
    end
  end

  assign dn_room  = !dn_valid || dn_ready;
  assign s1_adv   = s1_valid && (!emit || dn_room);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op     <= operation;
      s1_sample <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      running      <= 1'b0;
      level_high   <= 1'b0;
      sample_count <= '0;
      beat_count   <= '0;
    end else if (s1_adv) begin
      active       <= active_next;
      running      <= running_next;
      level_high   <= level_next;
      sample_count <= count_next;
      beat_count   <= beats_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (dn_room) begin
      dn_valid <= s1_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (dn_room && s1_valid && emit) begin
      dn_word <= word_next;
    end
  end

  `ASSERT_NEVER(a_run_needs_active, clk, rst, running && !active)
  `ASSERT_IMPLY(a_idle_is_clear, clk, rst, !active,
                sample_count == '0 && beat_count == '0 && !level_high)

endmodule

// ----- hw/rtl/brm_scale.sv -----
module brm_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  brm_pkg::beat_word_t  up_word,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output brm_pkg::rate_word_t  dn_word
);

  logic [brm_pkg::PROD_BITS-1:0] prod;
  brm_pkg::rate_word_t           word_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    prod = brm_pkg::PROD_BITS'(up_word.beats) * brm_pkg::PROD_BITS'(up_word.scale);
    word_next.rate = (prod > brm_pkg::PROD_BITS'(brm_pkg::RATE_MAX)) ?
                     brm_pkg::RATE_MAX : prod[brm_pkg::RATE_BITS-1:0];
    word_next.cleared = up_word.cleared;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_word <= word_next;
    end
  end

endmodule

// ----- hw/rtl/brm_bcd.sv -----
module brm_bcd (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  brm_pkg::rate_word_t             up_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [brm_pkg::RATE_BITS-1:0]   rate,
  output logic [3:0]                      hundreds_digit,
  output logic [3:0]                      tens_digit,
  output logic [3:0]                      ones_digit,
  output logic                            cleared
);

  localparam int MUL_BITS = brm_pkg::RATE_BITS + 13;

  logic                   q_valid;
  logic                   q_ready;
  brm_pkg::quot_word_t    q_word;
  logic [MUL_BITS-1:0]    recip;
  logic [brm_pkg::RATE_BITS-1:0] q_x100;
  logic [brm_pkg::REM_BITS-1:0]  rem;
  logic [3:0]             tens;

  assign recip = MUL_BITS'(up_word.rate) * MUL_BITS'(brm_pkg::RECIP_100);

  assign q_ready  = !out_valid || out_ready;
  assign up_ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (up_ready) begin
      q_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      q_word.rate    <= up_word.rate;
      q_word.quot    <= recip[brm_pkg::RECIP_SHIFT +: brm_pkg::QUO_BITS];
      q_word.cleared <= up_word.cleared;
    end
  end

  always_comb begin
    q_x100 = brm_pkg::RATE_BITS'({q_word.quot, 6'b0}) +
             brm_pkg::RATE_BITS'({q_word.quot, 5'b0}) +
             brm_pkg::RATE_BITS'({q_word.quot, 2'b0});
    rem    = brm_pkg::REM_BITS'(q_word.rate - q_x100);
    tens   = brm_pkg::tens_of(rem);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_ready) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      rate           <= q_word.rate;
      hundreds_digit <= (q_word.quot > brm_pkg::QUO_BITS'(9)) ?
                        4'd9 : q_word.quot[3:0];
      tens_digit     <= tens;
      ones_digit     <= brm_pkg::ones_of(rem, tens);
      cleared        <= q_word.cleared;
    end
  end

endmodule

// ----- hw/rtl/beat_rate_meter.sv -----
// channel  | handshake               | word
// in       | in_valid / in_ready     | operation, sample
// cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
// out      | out_valid / out_ready   | rate, hundreds_digit, tens_digit, ones_digit, cleared
//
// One word accepted per cycle unless back-pressure on out stalls the step; a result
// passes the input reg, step, scale multiply, reciprocal divide and output reg.
// cfg_ready is always high; each write is registered in brm_cfg.
// rst clears the valid flags and the step state; registers return to 100 / 500 / 12.
// Back-pressure on out ripples up stage by stage; words with no result
// never occupy the stages after the step.
`include "assert_macros.svh"

module beat_rate_meter #(
  parameter int SAMPLE_BITS = 12,
  parameter int MAX_WINDOW  = 1023
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            operation,
  input  logic [11:0]                     sample,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [brm_pkg::IDX_BITS-1:0]    cfg_index,
  input  logic [brm_pkg::CFG_BITS-1:0]    cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [brm_pkg::RATE_BITS-1:0]   rate,
  output logic [3:0]                      hundreds_digit,
  output logic [3:0]                      tens_digit,
  output logic [3:0]                      ones_digit,
  output logic                            cleared
);

  brm_pkg::cfg_t        cfg;
  logic                 ev_valid, ev_ready;
  brm_pkg::beat_word_t  ev_word;
  logic                 rt_valid, rt_ready;
  brm_pkg::rate_word_t  rt_word;

  assign cfg_ready = 1'b1;

  brm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  brm_step #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .sample    (sample),
    .dn_valid  (ev_valid),
    .dn_ready  (ev_ready),
    .dn_word   (ev_word)
  );

  brm_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .up_valid (ev_valid),
    .up_ready (ev_ready),
    .up_word  (ev_word),
    .dn_valid (rt_valid),
    .dn_ready (rt_ready),
    .dn_word  (rt_word)
  );

  brm_bcd u_bcd (
    .clk            (clk),
    .rst            (rst),
    .up_valid       (rt_valid),
    .up_ready       (rt_ready),
    .up_word        (rt_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .rate           (rate),
    .hundreds_digit (hundreds_digit),
    .tens_digit     (tens_digit),
    .ones_digit     (ones_digit),
    .cleared        (cleared)
  );

  `ASSERT_IMPLY(a_cleared_is_zero, clk, rst, out_valid && cleared,
                rate == '0 && hundreds_digit == '0 && tens_digit == '0 && ones_digit == '0)
  `ASSERT_IMPLY(a_digits_bcd, clk, rst, out_valid,
                hundreds_digit <= 4'd9 && tens_digit <= 4'd9 && ones_digit <= 4'd9)
  `ASSERT_IMPLY(a_hundreds_sat, clk, rst, out_valid && rate >= 15'd1000,
                hundreds_digit == 4'd9)

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic [brm_pkg::IDX_BITS-1:0] REG_SPARE = 2'd3;
  localparam int DRAIN = 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_WORDS = 1325;
  localparam int PLAN_LEN = 35;

  typedef struct packed {
    logic [brm_pkg::RATE_BITS-1:0] rate;
    logic [3:0]                    hundreds;
    logic [3:0]                    tens;
    logic [3:0]                    ones;
    logic                          clr;
  } reading_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_CHECK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                    kind;
    logic                         op;
    logic [brm_pkg::IDX_BITS-1:0] idx;
    logic [11:0]                  data;
    reading_t                     reading;
  } plan_row_t;

  localparam reading_t DISPLAY_OFF = '{15'd0, 4'd0, 4'd0, 4'd0, 1'b1};
  localparam reading_t ZERO_RATE   = '{15'd0, 4'd0, 4'd0, 4'd0, 1'b0};

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_WORD,  OP_SAMPLE,         2'd0,                   12'hFFF, '0},  // idle, ignored
    '{ROW_WORD,  brm_pkg::OP_BUTTON, 2'd0,                  12'h5A5, '0},
    '{ROW_CHECK, brm_pkg::OP_BUTTON, 2'd0,                  12'hA5A, DISPLAY_OFF},
    '{ROW_WORD,  brm_pkg::OP_BUTTON, 2'd0,                  12'h000, '0},
    '{ROW_WORD,  OP_SAMPLE,         2'd0,                   12'd100, '0},  // at threshold
    '{ROW_WORD,  OP_SAMPLE,         2'd0,                   12'd99,  '0},
    '{ROW_WORD,  OP_SAMPLE,         2'd0,                   12'hFFF, '0},
    '{ROW_WORD,  OP_SAMPLE,         2'd0,                   12'h000, '0},
    '{ROW_CHECK, brm_pkg::OP_BUTTON, 2'd0,                  12'hFFF, DISPLAY_OFF},
    '{ROW_CFG,   OP_SAMPLE,         brm_pkg::REG_WINDOW,    12'd3,   '0},
    '{ROW_WORD,  brm_pkg::OP_BUTTON, 2'd0,                  12'h000, '0},
    '{ROW_WORD,  OP_SAMPLE,         2'd0,                   12'd0,   '0},
    '{ROW_WORD,  OP_SAMPLE,         2'd0,                   12'd200, '0},
    '{ROW_WORD,  OP_SAMPLE,         2'd0,                   12'd50,  '0},
    '{ROW_CHECK, OP_SAMPLE,         2'd0,                   12'd100,
      '{15'd12, 4'd0, 4'd1, 4'd2, 1'b0}},
    '{ROW_CFG,   OP_SAMPLE,         brm_pkg::REG_THRESHOLD, 12'hFFF, '0},
    '{ROW_CFG,   OP_SAMPLE,         brm_pkg::REG_WINDOW,    12'd1,   '0},
    '{ROW_CFG,   OP_SAMPLE,         brm_pkg::REG_SCALE,     12'd63,  '0},
    '{ROW_WORD,  OP_SAMPLE,         2'd0,                   12'h000, '0},
    '{ROW_CHECK, OP_SAMPLE,         2'd0,                   12'hFFF, ZERO_RATE},
    '{ROW_CFG,   OP_SAMPLE,         brm_pkg::REG_WINDOW,    12'd0,   '0},
    '{ROW_WORD,  OP_SAMPLE,         2'd0,                   12'hFFE, '0},
    '{ROW_CHECK, OP_SAMPLE,         2'd0,                   12'hFFE, ZERO_RATE},
    '{ROW_CFG,   OP_SAMPLE,         brm_pkg::REG_THRESHOLD, 12'h000, '0},
    '{ROW_WORD,  OP_SAMPLE,         2'd0,                   12'h000, '0},  // nothing below
    '{ROW_CFG,   OP_SAMPLE,         brm_pkg::REG_THRESHOLD, 12'h800, '0},
    '{ROW_CFG,   OP_SAMPLE,         brm_pkg::REG_WINDOW,    12'd5,   '0},
    '{ROW_WORD,  OP_SAMPLE,         2'd0,                   12'h7FF, '0},
    '{ROW_WORD,  OP_SAMPLE,         2'd0,                   12'h800, '0},
    '{ROW_WORD,  OP_SAMPLE,         2'd0,                   12'h7FF, '0},
    '{ROW_WORD,  OP_SAMPLE,         2'd0,                   12'h800, '0},
    '{ROW_WORD,  OP_SAMPLE,         2'd0,                   12'h000, '0},
    '{ROW_CHECK, OP_SAMPLE,         2'd0,                   12'hFFF,
      '{15'd126, 4'd1, 4'd2, 4'd6, 1'b0}},
    '{ROW_CHECK, brm_pkg::OP_BUTTON, 2'd0,                  12'h3C3, DISPLAY_OFF},
    '{ROW_WORD,  OP_SAMPLE,         2'd0,                   12'h123, '0}
  };

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic                          operation;
  logic [11:0]                   sample;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [brm_pkg::IDX_BITS-1:0]  cfg_index;
  logic [brm_pkg::CFG_BITS-1:0]  cfg_data;
  logic                          out_valid;
  logic                          out_ready;
  logic [brm_pkg::RATE_BITS-1:0] rate;
  logic [3:0]                    hundreds_digit;
  logic [3:0]                    tens_digit;
  logic [3:0]                    ones_digit;
  logic                          cleared;

  logic     typed_on;
  reading_t typed_reading;

  logic [brm_pkg::THR_BITS-1:0]   thr_reg = brm_pkg::RESET_THRESHOLD;
  logic [brm_pkg::WIN_BITS-1:0]   win_reg = brm_pkg::RESET_WINDOW;
  logic [brm_pkg::SCALE_BITS-1:0] scale_reg = brm_pkg::RESET_SCALE;
  logic                           acq_on = 1'b0;
  logic                           win_open = 1'b0;
  logic                           seen_high = 1'b0;
  logic [brm_pkg::WIN_BITS-1:0]   win_samples = '0;
  logic [brm_pkg::BEAT_BITS-1:0]  beats = '0;

  reading_t readings_due[$];

  int  mismatches = 0;
  int  n_words = 0;
  int  n_results = 0;
  int  n_clears = 0;
  int  n_pinned = 0;
  int  n_settings = 0;
  int  cycles = 0;
  bit  calm = 1'b0;
  bit  gen_active = 1'b0;

  beat_rate_meter dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic reading_t make_reading(input int r, input logic clr);
    reading_t w;
    w.rate     = brm_pkg::RATE_BITS'(r);
    w.hundreds = (r / 100 > 9) ? 4'd9 : 4'(r / 100);
    w.tens     = 4'((r % 100) / 10);
    w.ones     = 4'(r % 10);
    w.clr      = clr;
    return w;
  endfunction

  function automatic void drop_window();
    win_open = 1'b0;
    seen_high = 1'b0;
    win_samples = '0;
    beats = '0;
  endfunction

  function automatic bit meter_step(input logic op, input logic [11:0] smp,
                                    output reading_t w);
    int len;
    int prod;
    w = '0;
    if (op == brm_pkg::OP_BUTTON) begin
      drop_window();
      acq_on = !acq_on;
      if (!acq_on) begin
        w = make_reading(0, 1'b1);
        return 1'b1;
      end
      return 1'b0;
    end
    if (!acq_on) return 1'b0;
    if (!win_open) begin
      if (smp < thr_reg) begin
        drop_window();
        win_open = 1'b1;
      end
      return 1'b0;
    end
    if (smp >= thr_reg) begin
      seen_high = 1'b1;
    end else if (seen_high) begin
      seen_high = 1'b0;
      if (beats < brm_pkg::BEAT_MAX) beats++;
    end
    win_samples++;
    len = (win_reg == '0) ? 1 : int'(win_reg);
    if (int'(win_samples) < len) return 1'b0;
    prod = int'(beats) * int'(scale_reg);
    if (prod > int'(brm_pkg::RATE_MAX)) prod = int'(brm_pkg::RATE_MAX);
    drop_window();
    w = make_reading(prod, 1'b0);
    return 1'b1;
  endfunction

  // words and register writes, in acceptance order
  always @(posedge clk) begin : word_monitor
    reading_t w;
    bit       has_res;
    if (!rst && in_valid && in_ready) begin
      n_words++;
      has_res = meter_step(operation, sample, w);
      if (typed_on) readings_due.push_back(typed_reading);
      else if (has_res) readings_due.push_back(w);
    end
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        brm_pkg::REG_THRESHOLD: thr_reg = cfg_data[brm_pkg::THR_BITS-1:0];
        brm_pkg::REG_WINDOW:    win_reg = cfg_data[brm_pkg::WIN_BITS-1:0];
        brm_pkg::REG_SCALE:     scale_reg = cfg_data[brm_pkg::SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin : reading_check
    reading_t got;
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      got = {rate, hundreds_digit, tens_digit, ones_digit, cleared};
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reading: rate %0d digits %0d%0d%0d clr %0b",
                   got.rate, got.hundreds, got.tens, got.ones, got.clr);
      end else begin
        want = readings_due.pop_front();
        n_results++;
        if (want.clr) n_clears++;
        if (want.rate >= 15'd1000) n_pinned++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reading mismatch: exp rate %0d digits %0d%0d%0d clr %0b, %s",
                     want.rate, want.hundreds, want.tens, want.ones, want.clr,
                     $sformatf("got rate %0d digits %0d%0d%0d clr %0b",
                               got.rate, got.hundreds, got.tens, got.ones, got.clr));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readings outstanding", cycles,
               readings_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  initial begin : sink_stall
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  end

  task automatic put_word(input logic op, input logic [11:0] smp, input logic chk,
                          input reading_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    sample <= smp;
    typed_on <= chk;
    typed_reading <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // only once the pipeline has emptied, including words that give no reading
  task automatic write_reg(input logic [brm_pkg::IDX_BITS-1:0] idx,
                           input logic [brm_pkg::CFG_BITS-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [11:0] level_sample(input bit want_high, input logic [11:0] thr);
    int r;
    r = $urandom_range(9, 0);
    if (want_high || thr == '0)
      return (r == 0) ? thr : 12'($urandom_range(4095, int'(thr)));
    return (r == 0) ? thr - 12'd1 : 12'($urandom_range(int'(thr) - 1, 0));
  endfunction

  task automatic run_phase(input int pidx, inout int counted);
    logic [11:0] thr;
    int          win;
    int          scl;
    int          len;
    int          budget;
    int          done;
    int          r;
    int          n;
    int          k;
    bit          lvl;
    case (pidx)
      0: begin
        thr = 12'($urandom_range(4095, 1));
        win = 1023;
        scl = 63;
      end
      1: begin
        thr = 12'd0;
        win = $urandom_range(9, 2);
        scl = $urandom_range(63, 0);
      end
      2: begin
        thr = 12'hFFF;
        win = $urandom_range(9, 2);
        scl = 0;
      end
      3: begin
        thr = 12'd1;
        win = 2;
        scl = 1;
      end
      default: begin
        thr = 12'($urandom_range(4095, 1));
        win = ($urandom_range(99, 0) < 15) ? $urandom_range(1, 0) : $urandom_range(12, 2);
        scl = $urandom_range(63, 0);
      end
    endcase
    calm = ($urandom_range(3, 0) == 0);
    write_reg(brm_pkg::REG_THRESHOLD, thr);
    write_reg(brm_pkg::REG_WINDOW, {2'($urandom), 10'(win)});
    write_reg(brm_pkg::REG_SCALE, {6'($urandom), 6'(scl)});
    if ($urandom_range(3, 0) == 0) write_reg(REG_SPARE, 12'($urandom));
    n_settings++;
    len = (win == 0) ? 1 : win;
    budget = (pidx == 0) ? len + 2 : $urandom_range(60, 25);
    done = 0;
    while (done < budget) begin
      r = (pidx == 0) ? 99 : $urandom_range(99, 0);
      if (r < 4) begin
        put_word(brm_pkg::OP_BUTTON, 12'($urandom), 1'b0, '0);
        gen_active = !gen_active;
        done++;
      end else if (r < 10) begin
        put_word(OP_SAMPLE, 12'($urandom), 1'b0, '0);
        if (gen_active) done++;
      end else begin
        if (!gen_active) begin
          put_word(brm_pkg::OP_BUTTON, 12'($urandom), 1'b0, '0);
          gen_active = 1'b1;
          done++;
        end
        put_word(OP_SAMPLE, level_sample(1'b0, thr), 1'b0, '0);
        done++;
        lvl = 1'($urandom_range(1, 0));
        n = len;
        if (r < 16 && len > 1) n = $urandom_range(len - 1, 0);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(99, 0) < 65) lvl = !lvl;
          put_word(OP_SAMPLE, level_sample(lvl, thr), 1'b0, '0);
          done++;
        end
        if (n < len) begin
          put_word(brm_pkg::OP_BUTTON, 12'($urandom), 1'b0, '0);
          gen_active = 1'b0;
          done++;
        end
      end
    end
    counted += done;
  endtask

  initial begin : stimulus
    int counted;
    int pidx;
    rst <= 1'b1;
    in_valid <= 1'b0;
    operation <= OP_SAMPLE;
    sample <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= brm_pkg::REG_THRESHOLD;
    cfg_data <= '0;
    typed_on <= 1'b0;
    typed_reading <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CFG) write_reg(PLAN[i].idx, PLAN[i].data);
      else put_word(PLAN[i].op, PLAN[i].data, PLAN[i].kind == ROW_CHECK, PLAN[i].reading);
    end

    counted = 0;
    pidx = 0;
    while (pidx < 4 || counted < RANDOM_WORDS) begin
      run_phase(pidx, counted);
      pidx++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("%0d words sent over %0d register settings incl. a 1023-sample window",
             n_words, n_settings);
    $display("%0d readings checked: %0d display clears, %0d with hundreds held at 9",
             n_results, n_clears, n_pinned);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
